>>> sv/sact_pkg.sv
// Shared constants for the cache tag and replacement block.
`default_nettype none
package sact_pkg;
  localparam logic [2:0] MODE_FIRST  = 3'd0;
  localparam logic [2:0] MODE_LRU    = 3'd1;
  localparam logic [2:0] MODE_MRU    = 3'd2;
  localparam logic [2:0] MODE_FIFO   = 3'd3;
  localparam logic [2:0] MODE_RANDOM = 3'd4;
  localparam logic [0:0] OP_READ  = 1'b0;
  localparam logic [0:0] OP_WRITE = 1'b1;
  localparam int unsigned MAX_LINES = 5;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam int unsigned REG_WRITE_THROUGH = 0;
  localparam int unsigned REG_REPLACE_MODE  = 1;
endpackage
`default_nettype wire

>>> sv/sact_set_mem.sv
// One row per set: valid, dirty, tag and age of all ways; registered read.
`default_nettype none
module sact_set_mem #(
  parameter int unsigned ROW_W = 8,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [ROW_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [ROW_W-1:0] wr_data
);
  logic [ROW_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

>>> sv/set_assoc_cache_tag_policy.sv
// Top level: set-associative tag store with selectable replacement policy.
//
// Usage: pulse start with an access (operation, set index, tag, byte offset,
// byte count) while busy is low. The block walks the lines the access
// touches (at most five, consecutive sets, same tag) and gives one result
// per line on the out_ ports, marked by out_valid for one cycle; out_last
// flags the final line. A zero-byte access gives no result.
// For each line the block reads the set row from the row memory, then does
// lookup, victim choice and write back, then loads the result registers.
// Busy stays high until every line of the access has been walked.
// After reset the block sweeps the row memory to clear valid, dirty and age,
// one set a cycle with busy high; configuration writes are taken throughout.
// The receiver cannot stall: results are never held.
// Registers: write_through at 0x0, replace_mode at 0x4 (reset 1, LRU).
`default_nettype none
module set_assoc_cache_tag_policy #(
  parameter int unsigned NUM_SETS   = 64,
  parameter int unsigned NUM_WAYS   = 4,
  parameter int unsigned LINE_BYTES = 16,
  parameter int unsigned AGE_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [5:0]  in_set_index,
  input  wire logic [31:0] in_tag,
  input  wire logic [3:0]  in_byte_offset,
  input  wire logic [6:0]  in_access_bytes,
  output logic             out_valid,
  output logic [1:0]       out_way,
  output logic             out_hit,
  output logic             out_dirty_evict,
  output logic             out_mem_write,
  output logic             out_last,
  output logic [31:0]      out_hit_total,
  output logic [31:0]      out_miss_total,
  output logic [31:0]      out_read_total,
  output logic [31:0]      out_write_total,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned OFF_W  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int unsigned ENT_W  = 2 + 32 + AGE_BITS;
  localparam int unsigned ROW_W  = ENT_W * NUM_WAYS;
  localparam int unsigned SWP_W  = $clog2(NUM_SETS + 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
  localparam logic [AGE_BITS-1:0] AGE_ONE = {{(AGE_BITS-1){1'b0}}, 1'b1};

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // Config registers
  logic       wt_r;
  logic [2:0] mode_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r   <= 1'b0;
      mode_r <= sact_pkg::MODE_LRU;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == sact_pkg::REG_REPLACE_MODE[0]) begin
        mode_r <= cfg_pwdata[2:0];
      end else begin
        wt_r <= cfg_pwdata[0];
      end
    end
  end
  always_comb begin
    if (cfg_paddr[2] == sact_pkg::REG_REPLACE_MODE[0]) begin
      cfg_prdata = {29'd0, mode_r};
    end else begin
      cfg_prdata = {31'd0, wt_r};
    end
  end

  // Control and access registers
  logic [2:0]       st_r, st_nxt;
  logic [SWP_W-1:0] swp_r;
  logic [SET_W-1:0] set_r;
  logic [31:0]      tag_r;
  logic             op_r;
  logic [2:0]       left_r;
  logic [15:0]      lfsr_r;
  logic [31:0]      hits_r, miss_r, rds_r, wrs_r;

  // Line count: lines = ceil((off + bytes)/LINE_BYTES), capped at five
  logic [OFF_W-1:0] off_m;
  logic [8:0]       span;
  logic [8:0]       nlines;
  logic [2:0]       nl_cap;
  assign off_m  = OFF_W'(in_byte_offset % LINE_BYTES);
  assign span   = 9'(off_m) + 9'(in_access_bytes) + 9'(LINE_BYTES - 1);
  assign nlines = (in_access_bytes == 7'd0) ? 9'd0 : 9'(span / LINE_BYTES);
  assign nl_cap = (nlines > 9'd5) ? 3'd5 : nlines[2:0];

  // Row memory
  logic             rd_en, wr_en;
  logic [SET_W-1:0] rd_addr, wr_addr;
  logic [ROW_W-1:0] rd_row, wr_row, upd_row;
  sact_set_mem #(.ROW_W(ROW_W), .IDX_W(SET_W), .DEPTH(NUM_SETS)) u_mem (
    .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_row),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_row)
  );
  assign rd_en   = (st_r == ST_READ);
  assign rd_addr = set_r;
  assign wr_en   = (st_r == ST_SWEEP) || (st_r == ST_UPD);
  assign wr_addr = (st_r == ST_SWEEP) ? swp_r[SET_W-1:0] : set_r;
  assign wr_row  = (st_r == ST_SWEEP) ? '0 : upd_row;

  // Lookup and update of one set row
  logic [NUM_WAYS-1:0] vld, drt, hitv;
  logic [31:0]         tg [NUM_WAYS];
  logic [AGE_BITS-1:0] ag [NUM_WAYS];
  logic                hit, all_valid, evict, touch, inv_found;
  logic [WAY_W-1:0]    way, hway, inv_way, old_way, young_way, vict;
  logic [15:0]         lfsr_adv;
  logic                lfsr_step;
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      vld[w]  = rd_row[w*ENT_W];
      drt[w]  = rd_row[w*ENT_W+1];
      tg[w]   = rd_row[w*ENT_W+2 +: 32];
      ag[w]   = rd_row[w*ENT_W+34 +: AGE_BITS];
      hitv[w] = vld[w] && (tg[w] == tag_r);
    end
  end
  // Priority search for hit, invalid, oldest and youngest way
  always_comb begin
    hit = 1'b0; hway = '0; inv_found = 1'b0; inv_way = '0;
    old_way = '0; young_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) begin
        hit = 1'b1; hway = WAY_W'(w);
      end
      if (!vld[w]) begin
        inv_found = 1'b1; inv_way = WAY_W'(w);
      end
    end
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (ag[w] > ag[old_way]) old_way = WAY_W'(w);
      if (ag[w] < ag[young_way]) young_way = WAY_W'(w);
    end
  end
  assign all_valid = !inv_found;
  assign lfsr_adv  = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
  assign lfsr_step = !hit && all_valid && (mode_r == sact_pkg::MODE_RANDOM);
  always_comb begin
    if (inv_found) begin
      vict = inv_way;
    end else begin
      case (mode_r)
        sact_pkg::MODE_LRU, sact_pkg::MODE_FIFO: vict = old_way;
        sact_pkg::MODE_MRU:    vict = young_way;
        sact_pkg::MODE_RANDOM: vict = WAY_W'(lfsr_adv % NUM_WAYS);
        default:               vict = '0;
      endcase
    end
  end
  assign way   = hit ? hway : vict;
  assign evict = !hit && vld[way] && drt[way];
  assign touch = (mode_r == sact_pkg::MODE_LRU) || (mode_r == sact_pkg::MODE_MRU) ||
                 (!hit && (mode_r == sact_pkg::MODE_FIFO));
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      logic                v, d;
      logic [31:0]         t;
      logic [AGE_BITS-1:0] a;
      v = vld[w]; d = drt[w]; t = tg[w]; a = ag[w];
      if (touch) begin
        if (WAY_W'(w) == way) begin
          a = AGE_ONE;
        end else if (vld[w] && ag[w] < AGE_MAX) begin
          a = ag[w] + AGE_ONE;
        end
      end
      if (WAY_W'(w) == way) begin
        if (!hit) begin
          v = 1'b1; d = 1'b0; t = tag_r;
        end
        if (op_r == sact_pkg::OP_WRITE) begin
          d = !wt_r;
        end
      end
      upd_row[w*ENT_W +: ENT_W] = {a, t, d, v};
    end
  end

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_SWEEP: if (swp_r == SWP_W'(NUM_SETS - 1)) st_nxt = ST_IDLE;
      ST_IDLE:  if (start && nl_cap != 3'd0) st_nxt = ST_READ;
      ST_READ:  st_nxt = ST_UPD;
      ST_UPD:   st_nxt = ST_OUT;
      ST_OUT:   st_nxt = (left_r == 3'd1) ? ST_IDLE : ST_READ;
      default:  st_nxt = ST_IDLE;
    endcase
  end
  assign busy = (st_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_SWEEP;
      swp_r  <= '0;
      lfsr_r <= sact_pkg::LFSR_SEED;
      hits_r <= '0; miss_r <= '0; rds_r <= '0; wrs_r <= '0;
      out_valid <= 1'b0;
      left_r <= '0;
    end else begin
      st_r <= st_nxt;
      out_valid <= 1'b0;
      if (st_r == ST_SWEEP) swp_r <= swp_r + 1'b1;
      if (st_r == ST_IDLE && start) left_r <= nl_cap;
      if (st_r == ST_UPD) begin
        if (lfsr_step) lfsr_r <= lfsr_adv;
        if (hit) hits_r <= hits_r + 32'd1; else miss_r <= miss_r + 32'd1;
        if (op_r == sact_pkg::OP_WRITE) wrs_r <= wrs_r + 32'd1;
        else rds_r <= rds_r + 32'd1;
      end
      if (st_r == ST_OUT) begin
        out_valid <= 1'b1;
        left_r    <= left_r - 3'd1;
      end
    end
  end

  // Access payload and per-line result hold
  logic [1:0] way_q;
  logic       hit_q, ev_q, mw_q;
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && start) begin
      op_r  <= in_operation;
      set_r <= SET_W'(32'(in_set_index) % NUM_SETS);
      tag_r <= in_tag;
    end
    if (st_r == ST_UPD) begin
      way_q <= 2'(32'(way));
      hit_q <= hit;
      ev_q  <= evict;
      mw_q  <= (op_r == sact_pkg::OP_WRITE) && wt_r;
    end
    if (st_r == ST_OUT) begin
      set_r <= (32'(set_r) == NUM_SETS - 1) ? '0 : set_r + 1'b1;
      out_way         <= way_q;
      out_hit         <= hit_q;
      out_dirty_evict <= ev_q;
      out_mem_write   <= mw_q;
      out_last        <= (left_r == 3'd1);
      out_hit_total   <= hits_r;
      out_miss_total  <= miss_r;
      out_read_total  <= rds_r;
      out_write_total <= wrs_r;
    end
  end
endmodule
`default_nettype wire
